// ===== hdl/pgt_pkg.sv =====
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared types and constants of the palette gradient table.
// ----------------------------------------------------------------------------
package pgt_pkg;

  localparam int OP_W  = 2;
  localparam int IDX_W = 8;
  localparam int COL_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_SPREAD = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_LOAD_HI,
    S_DIFF,
    S_DIV,
    S_STEP0,
    S_FILL,
    S_DONE
  } state_t;

endpackage

// ===== hdl/pgt_if.sv =====
// ----------------------------------------------------------------------------
// pgt_if
// Valid/ready channels of the palette gradient table: operations in,
// completions out.
// ----------------------------------------------------------------------------
interface pgt_in_if;
  import pgt_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] index_first;
  logic [IDX_W-1:0] index_second;
  logic [COL_W-1:0] red_in;
  logic [COL_W-1:0] green_in;
  logic [COL_W-1:0] blue_in;

  modport source (output valid, opcode, index_first, index_second, red_in, green_in,
                  blue_in, input ready);
  modport sink   (input valid, opcode, index_first, index_second, red_in, green_in,
                  blue_in, output ready);
endinterface

interface pgt_out_if;
  import pgt_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  kind_done;
  logic [COL_W-1:0] red_out;
  logic [COL_W-1:0] green_out;
  logic [COL_W-1:0] blue_out;

  modport source (output valid, kind_done, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, kind_done, red_out, green_out, blue_out, output ready);
endinterface

// ===== hdl/palette_gradient_table.sv =====
// ----------------------------------------------------------------------------
// palette_gradient_table
// Colour table with write, read and linear gradient spread between two
// entries. Spread: exact floor interpolation per channel, one entry a cycle.
// ----------------------------------------------------------------------------
// A spread with gap < 2 or an end out of range skips the fill and goes to S_DONE.
// One operation at a time; the next transfer is taken the cycle after the
//   result is loaded. The spread fill writes one entry per cycle into the
//   single-write-port table, after a bit-serial step division.
// Reset clears control state only; table contents are undefined until written.
module palette_gradient_table #(
  parameter int ENTRIES      = 256,
  parameter int CHANNEL_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  pgt_in_if.sink    in_ch,
  pgt_out_if.source out_ch
);
  import pgt_pkg::*;

  localparam int CB    = CHANNEL_BITS;
  localparam int AW    = $clog2(ENTRIES);
  localparam int WW    = 3 * CB;
  localparam int CNT_W = $clog2(CB);

  state_t state_r, state_nxt;

  // table port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  // operation
  logic [OP_W-1:0]  kind_r;
  logic [IDX_W-1:0] lo_r, hi_r, gap_r, fill_addr_r;
  logic [CNT_W-1:0] div_cnt_r;

  // per channel
  logic [CB-1:0]    lo_val_r  [3];
  logic             neg_r     [3];
  logic [CB-1:0]    dvd_r     [3];
  logic [IDX_W-1:0] rem_r     [3];
  logic [CB:0]      qd_r      [3];
  logic [IDX_W-1:0] rd_r      [3];
  logic [CB-1:0]    val_r     [3];
  logic [IDX_W-1:0] acc_r     [3];

  logic [IDX_W-1:0] rem_step  [3];
  logic             qbit      [3];
  logic [CB-1:0]    val_step  [3];
  logic [IDX_W-1:0] acc_step  [3];

  // result and output
  logic [COL_W-1:0] res_col_r [3];
  logic             out_valid_r;
  logic [OP_W-1:0]  out_kind_r;
  logic [COL_W-1:0] out_col_r [3];

  logic             in_xfer;
  logic             out_free;
  logic             ia_ok, ib_ok;
  logic [IDX_W-1:0] in_lo, in_hi, in_gap;
  logic [CB-1:0]    hi_val    [3];

  pgt_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign ia_ok  = 32'(in_ch.index_first) < 32'(ENTRIES);
  assign ib_ok  = 32'(in_ch.index_second) < 32'(ENTRIES);
  assign in_lo  = (in_ch.index_first < in_ch.index_second) ? in_ch.index_first
                                                           : in_ch.index_second;
  assign in_hi  = (in_ch.index_first < in_ch.index_second) ? in_ch.index_second
                                                           : in_ch.index_first;
  assign in_gap = in_hi - in_lo;

  // datapath arithmetic
  always_comb begin
    logic [IDX_W:0]  t;
    logic [IDX_W:0]  r2;
    logic            cy;
    logic [CB+1:0]   sum;
    for (int c = 0; c < 3; c++) begin
      hi_val[c]   = ram_rdata[c*CB +: CB];
      // restoring division step
      t           = {rem_r[c], dvd_r[c][CB-1]};
      qbit[c]     = t >= {1'b0, gap_r};
      rem_step[c] = qbit[c] ? IDX_W'(t - {1'b0, gap_r}) : IDX_W'(t);
      // incremental interpolation step
      r2          = {1'b0, acc_r[c]} + {1'b0, rd_r[c]};
      cy          = r2 >= {1'b0, gap_r};
      acc_step[c] = cy ? IDX_W'(r2 - {1'b0, gap_r}) : IDX_W'(r2);
      sum         = {2'b00, val_r[c]} + {qd_r[c][CB], qd_r[c]} + (CB+2)'(cy);
      val_step[c] = sum[CB-1:0];
    end
  end

  // next state and table port
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = AW'(fill_addr_r);
    ram_raddr = AW'(in_ch.index_first);
    for (int c = 0; c < 3; c++) begin
      ram_wdata[c*CB +: CB] = val_step[c];
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DONE;
          unique case (op_t'(in_ch.opcode))
            OP_WRITE: begin
              ram_we    = ia_ok;
              ram_waddr = AW'(in_ch.index_first);
              ram_wdata = {CB'(in_ch.blue_in), CB'(in_ch.green_in), CB'(in_ch.red_in)};
            end
            OP_READ: begin
              if (ia_ok) begin
                state_nxt = S_RDATA;
              end
            end
            OP_SPREAD: begin
              ram_raddr = AW'(in_lo);
              if (ia_ok && ib_ok && in_gap > IDX_W'(1)) begin
                state_nxt = S_LOAD_HI;
              end
            end
            OP_NONE: ;
          endcase
        end
      end
      S_RDATA:   state_nxt = S_DONE;
      S_LOAD_HI: begin
        ram_raddr = AW'(hi_r);
        state_nxt = S_DIFF;
      end
      S_DIFF:    state_nxt = S_DIV;
      S_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = S_STEP0;
        end
      end
      S_STEP0:   state_nxt = S_FILL;
      S_FILL: begin
        ram_we = 1'b1;
        if (fill_addr_r == hi_r - IDX_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          kind_r <= in_ch.opcode;
          lo_r   <= in_lo;
          hi_r   <= in_hi;
          gap_r  <= in_gap;
          for (int c = 0; c < 3; c++) begin
            res_col_r[c] <= '0;
          end
        end
      end
      S_RDATA: begin
        for (int c = 0; c < 3; c++) begin
          res_col_r[c] <= COL_W'(hi_val[c]);
        end
      end
      S_LOAD_HI: begin
        for (int c = 0; c < 3; c++) begin
          lo_val_r[c] <= hi_val[c];
        end
      end
      S_DIFF: begin
        div_cnt_r <= CNT_W'(CB - 1);
        for (int c = 0; c < 3; c++) begin
          neg_r[c] <= hi_val[c] < lo_val_r[c];
          dvd_r[c] <= (hi_val[c] < lo_val_r[c]) ? lo_val_r[c] - hi_val[c]
                                                : hi_val[c] - lo_val_r[c];
          rem_r[c] <= '0;
        end
      end
      S_DIV: begin
        div_cnt_r <= div_cnt_r - CNT_W'(1);
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= rem_step[c];
          dvd_r[c] <= {dvd_r[c][CB-2:0], qbit[c]};
        end
      end
      S_STEP0: begin
        fill_addr_r <= lo_r + IDX_W'(1);
        for (int c = 0; c < 3; c++) begin
          val_r[c] <= lo_val_r[c];
          acc_r[c] <= '0;
          if (!neg_r[c]) begin
            qd_r[c] <= {1'b0, dvd_r[c]};
            rd_r[c] <= rem_r[c];
          end else if (rem_r[c] == '0) begin
            qd_r[c] <= ~{1'b0, dvd_r[c]} + (CB+1)'(1);
            rd_r[c] <= '0;
          end else begin
            qd_r[c] <= ~{1'b0, dvd_r[c]};
            rd_r[c] <= gap_r - rem_r[c];
          end
        end
      end
      S_FILL: begin
        fill_addr_r <= fill_addr_r + IDX_W'(1);
        for (int c = 0; c < 3; c++) begin
          val_r[c] <= val_step[c];
          acc_r[c] <= acc_step[c];
        end
      end
      S_DONE: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_kind_r <= kind_r;
      for (int c = 0; c < 3; c++) begin
        out_col_r[c] <= res_col_r[c];
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind_done = out_kind_r;
  assign out_ch.red_out   = out_col_r[0];
  assign out_ch.green_out = out_col_r[1];
  assign out_ch.blue_out  = out_col_r[2];

  // checks
  a_fill_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> (fill_addr_r > lo_r && fill_addr_r < hi_r))
    else $error("fill address outside spread ends");

  a_fill_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> (acc_r[0] < gap_r && acc_r[1] < gap_r && acc_r[2] < gap_r))
    else $error("interpolation remainder not below gap");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("completed operation not presented");

endmodule

// ===== hdl/pgt_ram.sv =====
// ----------------------------------------------------------------------------
// pgt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pgt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== bench/pgt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pgt_checker
// Watches both channels of the palette gradient table. Keeps a shadow copy
// of the colour table, predicts one completion per accepted operation and
// compares every completion transfer, field by field, in order.
// ----------------------------------------------------------------------------
module pgt_checker (
  input  logic clk,
  input  logic rst_n,
  pgt_in_if    in_mon,
  pgt_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import pgt_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } shade_t;

  typedef struct packed {
    logic [OP_W-1:0]  kind;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } done_t;

  shade_t shades [256];
  done_t  done_q [$];
  int     bad_n;

  initial begin
    foreach (shades[i]) shades[i] = '0;
    bad_n = 0;
  end

  // lo + floor((hi - lo) * k / gap), floor toward minus infinity
  function automatic logic [COL_W-1:0] ramp(logic [COL_W-1:0] lo_v,
                                            logic [COL_W-1:0] hi_v,
                                            int k, int gap);
    int num;
    int q;
    num = (int'(hi_v) - int'(lo_v)) * k;
    if (num >= 0) q = num / gap;
    else q = -((-num + gap - 1) / gap);
    return COL_W'(int'(lo_v) + q);
  endfunction

  function automatic done_t predict_op(op_t op, logic [IDX_W-1:0] ia,
                                       logic [IDX_W-1:0] ib, logic [COL_W-1:0] r,
                                       logic [COL_W-1:0] g, logic [COL_W-1:0] b);
    done_t  res;
    int     lo;
    int     hi;
    shade_t lo_s;
    shade_t hi_s;
    res = '0;
    res.kind = op;
    case (op)
      OP_WRITE: begin
        shades[ia] = '{red: r, green: g, blue: b};
      end
      OP_SPREAD: begin
        lo = (ia < ib) ? int'(ia) : int'(ib);
        hi = (ia < ib) ? int'(ib) : int'(ia);
        lo_s = shades[lo];
        hi_s = shades[hi];
        for (int k = 1; k < hi - lo; k++) begin
          shades[lo + k] = '{red:   ramp(lo_s.red, hi_s.red, k, hi - lo),
                             green: ramp(lo_s.green, hi_s.green, k, hi - lo),
                             blue:  ramp(lo_s.blue, hi_s.blue, k, hi - lo)};
        end
      end
      OP_READ: begin
        res.red   = shades[ia].red;
        res.green = shades[ia].green;
        res.blue  = shades[ia].blue;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int field_bad(string name, logic [COL_W-1:0] want,
                                   logic [COL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    done_t want;
    if (!rst_n) begin
      done_q.delete();
      pending    <= 0;
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        done_q.push_back(predict_op(op_t'(in_mon.opcode), in_mon.index_first,
                                    in_mon.index_second, in_mon.red_in,
                                    in_mon.green_in, in_mon.blue_in));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (done_q.size() == 0) begin
          $error("completion transfer with nothing outstanding: kind_done %0d",
                 out_mon.kind_done);
          bad_n++;
        end else begin
          want = done_q.pop_front();
          bad_n += field_bad("kind_done", COL_W'(want.kind), COL_W'(out_mon.kind_done));
          bad_n += field_bad("red_out", want.red, out_mon.red_out);
          bad_n += field_bad("green_out", want.green, out_mon.green_out);
          bad_n += field_bad("blue_out", want.blue, out_mon.blue_out);
        end
      end
      pending    <= done_q.size();
      fail_count <= bad_n;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the palette gradient table: directed writes, reads and
// spreads over the table extremes, then random operations with bursts of
// idle cycles on both channels. Only entries already written are read or
// used as spread ends. The checker beside the block gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import pgt_pkg::*;

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   filled [256];
  int   fail_count;
  int   pending;

  pgt_in_if  in_ch ();
  pgt_out_if out_ch ();

  palette_gradient_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pgt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // completion side: random stall bursts while idle_on
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // nearest written entry at or above start, wrapping
  function automatic logic [IDX_W-1:0] pick_filled(int start);
    for (int i = 0; i < 256; i++) begin
      if (filled[(start + i) % 256]) return IDX_W'((start + i) % 256);
    end
    return '0;
  endfunction

  task automatic send_op(op_t op, logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                         logic [COL_W-1:0] r, logic [COL_W-1:0] g,
                         logic [COL_W-1:0] b);
    int lo;
    int hi;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.index_first  <= ia;
    in_ch.index_second <= ib;
    in_ch.red_in       <= r;
    in_ch.green_in     <= g;
    in_ch.blue_in      <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_WRITE) filled[ia] = 1'b1;
    if (op == OP_SPREAD) begin
      lo = (ia < ib) ? int'(ia) : int'(ib);
      hi = (ia < ib) ? int'(ib) : int'(ia);
      for (int i = lo; i <= hi; i++) filled[i] = 1'b1;
    end
  endtask

  // hold the sender until every completion is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_op();
    op_t              op;
    int               sel;
    int               span;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    sel = $urandom_range(0, 99);
    ia  = IDX_W'($urandom);
    ib  = IDX_W'($urandom);
    if (sel < 35) begin
      op = OP_WRITE;
    end else if (sel < 65) begin
      op = OP_READ;
      ia = pick_filled(ia);
    end else if (sel < 90) begin
      op = OP_SPREAD;
      ia = pick_filled(ia);
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
      ib = pick_filled(($urandom_range(0, 1) ? int'(ia) + span : int'(ia) - span + 256) % 256);
    end else begin
      op = OP_NONE;
    end
    send_op(op, ia, ib, COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
  endtask

  initial begin
    rst_n              <= 1'b0;
    idle_on            = 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_WRITE;
    in_ch.index_first  <= '0;
    in_ch.index_second <= '0;
    in_ch.red_in       <= '0;
    in_ch.green_in     <= '0;
    in_ch.blue_in      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table extremes, full reversed spread, falling ramps, degenerate spreads
    send_op(OP_WRITE, 8'd0, 8'd255, 8'h00, 8'h00, 8'h00);
    send_op(OP_WRITE, 8'd255, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_READ, 8'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_READ, 8'd255, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_SPREAD, 8'd255, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_READ, 8'd1, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_READ, 8'd128, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_READ, 8'd254, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_WRITE, 8'd10, 8'd0, 8'hFF, 8'h00, 8'h80);
    send_op(OP_WRITE, 8'd20, 8'd0, 8'h00, 8'hFF, 8'h7F);
    send_op(OP_SPREAD, 8'd10, 8'd20, 8'h00, 8'h00, 8'h00);
    send_op(OP_READ, 8'd11, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_READ, 8'd15, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_READ, 8'd19, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_WRITE, 8'd40, 8'd0, 8'hAA, 8'h55, 8'h01);
    send_op(OP_SPREAD, 8'd30, 8'd30, 8'h00, 8'h00, 8'h00);
    send_op(OP_SPREAD, 8'd41, 8'd40, 8'h00, 8'h00, 8'h00);
    send_op(OP_READ, 8'd40, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_READ, 8'd41, 8'd0, 8'h00, 8'h00, 8'h00);
    send_op(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_READ, 8'd30, 8'hFF, 8'h00, 8'h00, 8'h00);
    drain();

    for (int n = 0; n < 400; n++) begin
      if (n % 50 == 0) idle_on = (n < 340) && ($urandom_range(0, 3) != 0);
      if (n == 200) drain();
      random_op();
    end
    drain();
    repeat (300) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pgt_pkg.sv
hdl/pgt_if.sv
hdl/pgt_ram.sv
hdl/palette_gradient_table.sv
bench/pgt_checker.sv
bench/tb_top.sv
